// ===== src/he_pkg.sv =====
// ----------------------------------------------------------------------------
// he_pkg
// Shared types and constants for the histogram equalizer.
// ----------------------------------------------------------------------------
package he_pkg;

    localparam int unsigned BINS       = 256;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CNT_W      = 21;
    localparam int unsigned NUM_W      = CNT_W + PIX_W;
    localparam int unsigned MAX_PIXELS = 1048576;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_BLD_RD,
        ST_BLD_ACC,
        ST_BLD_DIV,
        ST_BLD_WR,
        ST_MAP_RD,
        ST_MAP_OUT
    } state_t;

endpackage

// ===== src/histogram_equalizer.sv =====
// ----------------------------------------------------------------------------
// histogram_equalizer
// Two-pass 8-bit histogram equalization on a 256-bin histogram memory.
// ----------------------------------------------------------------------------
// One request at a time. A count request reads and then writes its bin, or is
// accepted without a write once the pixel count has saturated. A map request
// with a valid table reads the table and then loads the output register,
// waiting while the output is stalled. The first map request of a frame first
// builds the table: per bin one memory read, one accumulate, a radix-2 divider
// and one table write (no divider when no pixels were counted). A count
// request after a map request starts a new frame; the bins clear at once
// through valid bits.
module histogram_equalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // pixel_value[7:0]
    input  logic       s_tuser,   // action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // mapped_pixel[7:0]
);

    localparam int unsigned PW = he_pkg::PIX_W;
    localparam int unsigned CW = he_pkg::CNT_W;
    localparam int unsigned NW = he_pkg::NUM_W;

    he_pkg::state_t state_reg, state_next;

    logic [CW-1:0] bin_mem [he_pkg::BINS];
    logic [PW-1:0] map_mem [he_pkg::BINS];
    logic [CW-1:0] bin_rd_reg;
    logic [PW-1:0] map_rd_reg;

    logic [he_pkg::BINS-1:0] valid_reg;
    logic [CW-1:0] pixels_reg;
    logic          table_valid_reg;
    logic          map_phase_reg;
    logic [PW-1:0] pix_reg;
    logic [PW-1:0] k_reg;
    logic [CW-1:0] running_reg;
    logic [CW-1:0] rem_reg;
    logic [PW-1:0] lo_reg;
    logic [PW-1:0] q_reg;
    logic [2:0]    step_reg;
    logic          out_valid_reg;
    logic [PW-1:0] out_data_reg;

    logic          accept;
    logic          cnt_ok;
    logic [PW-1:0] bin_raddr;
    logic          bin_we;
    logic [CW-1:0] bin_wdata;
    logic          map_we;
    logic          out_load;
    logic [CW-1:0] bin_val;
    logic [CW-1:0] sum;
    logic [NW-1:0] num;
    logic [CW:0]   trial;

    assign accept   = s_tvalid && s_tready;
    assign cnt_ok   = map_phase_reg || (pixels_reg < CW'(he_pkg::MAX_PIXELS));
    assign s_tready = (state_reg == he_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign bin_val = valid_reg[k_reg] ? bin_rd_reg : '0;
    assign sum     = running_reg + bin_val;
    assign num     = ({sum, {PW{1'b0}}} - NW'(sum)) + NW'(pixels_reg >> 1);
    assign trial   = {rem_reg, lo_reg[PW-1]} - {1'b0, pixels_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            he_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == he_pkg::ACT_COUNT)
                        state_next = cnt_ok ? he_pkg::ST_CNT_WR : he_pkg::ST_IDLE;
                    else
                        state_next = table_valid_reg ? he_pkg::ST_MAP_RD
                                                     : he_pkg::ST_BLD_RD;
                end
            end
            he_pkg::ST_CNT_WR:  state_next = he_pkg::ST_IDLE;
            he_pkg::ST_BLD_RD:  state_next = he_pkg::ST_BLD_ACC;
            he_pkg::ST_BLD_ACC:
                state_next = (pixels_reg == '0) ? he_pkg::ST_BLD_WR : he_pkg::ST_BLD_DIV;
            he_pkg::ST_BLD_DIV:
                state_next = (step_reg == 3'd7) ? he_pkg::ST_BLD_WR : he_pkg::ST_BLD_DIV;
            he_pkg::ST_BLD_WR:
                state_next = (k_reg == '1) ? he_pkg::ST_MAP_RD : he_pkg::ST_BLD_RD;
            he_pkg::ST_MAP_RD:  state_next = he_pkg::ST_MAP_OUT;
            he_pkg::ST_MAP_OUT:
                state_next = (!out_valid_reg || m_tready) ? he_pkg::ST_IDLE
                                                          : he_pkg::ST_MAP_OUT;
            default:            state_next = he_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        bin_raddr = (state_reg == he_pkg::ST_IDLE) ? s_tdata : k_reg;
        bin_we    = (state_reg == he_pkg::ST_CNT_WR);
        bin_wdata = (valid_reg[pix_reg] ? bin_rd_reg : '0) + CW'(1);
        map_we    = (state_reg == he_pkg::ST_BLD_WR);
        out_load  = (state_reg == he_pkg::ST_MAP_OUT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk)
    begin
        bin_rd_reg <= bin_mem[bin_raddr];
        if (bin_we)
            bin_mem[pix_reg] <= bin_wdata;
    end

    always_ff @(posedge clk)
    begin
        map_rd_reg <= map_mem[pix_reg];
        if (map_we)
            map_mem[k_reg] <= q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= he_pkg::ST_IDLE;
            valid_reg       <= '0;
            pixels_reg      <= '0;
            table_valid_reg <= 1'b0;
            map_phase_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (accept && s_tuser == he_pkg::ACT_COUNT)
            begin
                if (map_phase_reg)
                begin
                    valid_reg       <= '0;
                    table_valid_reg <= 1'b0;
                    map_phase_reg   <= 1'b0;
                    pixels_reg      <= CW'(1);
                end
                else if (cnt_ok)
                    pixels_reg <= pixels_reg + CW'(1);
            end
            if (accept && s_tuser == he_pkg::ACT_MAP)
                map_phase_reg <= 1'b1;
            if (bin_we)
                valid_reg[pix_reg] <= 1'b1;
            if (map_we && k_reg == '1)
                table_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg     <= s_tdata;
            k_reg       <= '0;
            running_reg <= '0;
        end
        unique case (state_reg)
            he_pkg::ST_BLD_ACC:
            begin
                running_reg <= sum;
                rem_reg     <= num[NW-1:PW];
                lo_reg      <= num[PW-1:0];
                q_reg       <= '0;
                step_reg    <= '0;
            end
            he_pkg::ST_BLD_DIV:
            begin
                if (!trial[CW])
                    rem_reg <= trial[CW-1:0];
                else
                    rem_reg <= {rem_reg[CW-2:0], lo_reg[PW-1]};
                q_reg    <= {q_reg[PW-2:0], !trial[CW]};
                lo_reg   <= {lo_reg[PW-2:0], 1'b0};
                step_reg <= step_reg + 3'd1;
            end
            he_pkg::ST_BLD_WR:
                k_reg <= k_reg + PW'(1);
            default:
            begin
            end
        endcase
        if (out_load)
            out_data_reg <= map_rd_reg;
    end

endmodule
